// File: src/spcr_pkg.sv
package spcr_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;
    localparam int ST_SQ0    = 3;
    localparam int ST_PROD   = ST_SQ0 + SQ_STEPS;
    localparam int ST_DIV0   = ST_PROD + 1;
    localparam int ST_OUT    = ST_DIV0 + DIV_STEPS;
    localparam int NUM_ST    = ST_OUT + 1;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_pos_z;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_pos_z;
        logic [30:0]        a_radius;
        logic [30:0]        b_radius;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] new_a_x;
        logic signed [31:0] new_a_y;
        logic signed [31:0] new_a_z;
        logic signed [31:0] new_b_x;
        logic signed [31:0] new_b_y;
        logic signed [31:0] new_b_z;
        logic               overlapped;
    } result_t;

    // Values that ride along with an item through the whole pipeline.
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic [31:0]      r;
        logic             lt;
        logic             hit;
        logic             zero;
    } carry_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: src/sphere_pair_collision_resolve.sv
// Sphere pair overlap correction, fully pipelined. One pair beat can enter
// every clock cycle while result_ready is high, and one result beat leaves
// per pair, in order. One stage forms the axis and its magnitudes, one
// squares them, one sums and tests for overlap, 32 stages extract the
// integer square root one bit per stage, one stage forms the products
// for the push, 32 stages run the restoring divider one quotient bit per
// stage (three lanes side by side), and a last stage adds and saturates.
// The square root and divider pipelines set the depth. Each stage moves
// forward whenever it is empty or the stage after it moves, so empty
// slots close up under a stalled output and pair_ready stays high until
// every stage holds an item. All coordinates are signed Q16.16; the
// arithmetic works in least steps, so the fraction width only names the
// format. When the centers coincide the push is along +x by half the
// radius sum, and corrected coordinates clamp to the 32-bit signed range.
module sphere_pair_collision_resolve
    import spcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_ready,
    input  pair_t   pair_data,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_data
);

    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] en;

    // A stage loads when it is empty or its content moves on.
    assign en[NUM_ST-1] = !v_reg[NUM_ST-1] || result_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NUM_ST - 1; gi++) begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate

    assign pair_ready   = en[0];
    assign result_valid = v_reg[NUM_ST-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= pair_valid;
            end
            for (int i = 1; i < NUM_ST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: axis A - B, its per-axis magnitude and the radius sum.
    carry_t c0_next, c0_reg;
    always_comb begin
        logic signed [32:0] d;
        c0_next      = '0;
        c0_next.a[0] = pair_data.a_pos_x;
        c0_next.a[1] = pair_data.a_pos_y;
        c0_next.a[2] = pair_data.a_pos_z;
        c0_next.b[0] = pair_data.b_pos_x;
        c0_next.b[1] = pair_data.b_pos_y;
        c0_next.b[2] = pair_data.b_pos_z;
        for (int k = 0; k < 3; k++) begin
            d = {c0_next.a[k][31], c0_next.a[k]} - {c0_next.b[k][31], c0_next.b[k]};
            c0_next.neg[k] = d[32];
            c0_next.m[k]   = d[32] ? 32'(-d) : d[31:0];
        end
        c0_next.r = {1'b0, pair_data.a_radius} + {1'b0, pair_data.b_radius};
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            c0_reg <= c0_next;
        end
    end

    // Stage 1: squares of the magnitudes and of the radius sum.
    carry_t           c1_next, c1_reg;
    logic [2:0][63:0] sq1_reg;
    logic [63:0]      rr1_reg;
    always_comb begin
        c1_next    = c0_reg;
        c1_next.lt = (c0_reg.m[0] < c0_reg.r) && (c0_reg.m[1] < c0_reg.r)
                     && (c0_reg.m[2] < c0_reg.r);
    end

    always_ff @(posedge clk) begin
        if (en[1]) begin
            c1_reg <= c1_next;
            for (int k = 0; k < 3; k++) begin
                sq1_reg[k] <= 64'(c0_reg.m[k]) * 64'(c0_reg.m[k]);
            end
            rr1_reg <= 64'(c0_reg.r) * 64'(c0_reg.r);
        end
    end

    // Stage 2: squared distance and the overlap test; it seeds the root.
    logic [63:0] sq_rem_reg  [0:SQ_STEPS];
    logic [31:0] sq_root_reg [0:SQ_STEPS];
    carry_t      sq_car_reg  [0:SQ_STEPS];
    carry_t      sq_car_next;
    logic [65:0] s2;
    assign s2 = 66'(sq1_reg[0]) + 66'(sq1_reg[1]) + 66'(sq1_reg[2]);

    always_comb begin
        sq_car_next      = c1_reg;
        sq_car_next.hit  = c1_reg.lt && (66'(rr1_reg) > s2);
        sq_car_next.zero = (s2 == '0);
    end

    always_ff @(posedge clk) begin
        if (en[2]) begin
            sq_car_reg[0]  <= sq_car_next;
            sq_rem_reg[0]  <= s2[63:0];
            sq_root_reg[0] <= '0;
        end
    end

    // Square root, one result bit per stage, most significant first.
    generate
        for (gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
            localparam int BIT = SQ_STEPS - 1 - gi;
            logic [63:0] trial;
            logic        take;
            assign trial = (64'(sq_root_reg[gi]) << (BIT + 1)) | (64'd1 << (2 * BIT));
            assign take  = sq_rem_reg[gi] >= trial;
            always_ff @(posedge clk) begin
                if (en[ST_SQ0+gi]) begin
                    sq_car_reg[gi+1]  <= sq_car_reg[gi];
                    sq_rem_reg[gi+1]  <= take ? sq_rem_reg[gi] - trial : sq_rem_reg[gi];
                    sq_root_reg[gi+1] <= take ? (sq_root_reg[gi] | (32'd1 << BIT))
                                              : sq_root_reg[gi];
                end
            end
        end
    endgenerate

    // Product stage: numerators |d| * (r - dist) and divisor 2 * dist.
    logic [2:0][63:0] dv_num_reg [0:DIV_STEPS];
    logic [2:0][31:0] dv_q_reg   [0:DIV_STEPS];
    logic [32:0]      dv_den_reg [0:DIV_STEPS];
    carry_t           dv_car_reg [0:DIV_STEPS];
    logic [31:0]      delta;
    assign delta = sq_car_reg[SQ_STEPS].r - sq_root_reg[SQ_STEPS];

    always_ff @(posedge clk) begin
        if (en[ST_PROD]) begin
            dv_car_reg[0] <= sq_car_reg[SQ_STEPS];
            dv_den_reg[0] <= {sq_root_reg[SQ_STEPS], 1'b0};
            dv_q_reg[0]   <= '0;
            for (int k = 0; k < 3; k++) begin
                dv_num_reg[0][k] <= 64'(sq_car_reg[SQ_STEPS].m[k]) * 64'(delta);
            end
        end
    end

    // Restoring divider, one quotient bit per stage for all three axes.
    generate
        for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
            localparam int BIT = DIV_STEPS - 1 - gi;
            logic [64:0] shd;
            assign shd = 65'(dv_den_reg[gi]) << BIT;
            always_ff @(posedge clk) begin
                if (en[ST_DIV0+gi]) begin
                    dv_car_reg[gi+1] <= dv_car_reg[gi];
                    dv_den_reg[gi+1] <= dv_den_reg[gi];
                    for (int k = 0; k < 3; k++) begin
                        if ({1'b0, dv_num_reg[gi][k]} >= shd) begin
                            dv_num_reg[gi+1][k] <= dv_num_reg[gi][k] - shd[63:0];
                            dv_q_reg[gi+1][k]   <= dv_q_reg[gi][k] | (32'd1 << BIT);
                        end else begin
                            dv_num_reg[gi+1][k] <= dv_num_reg[gi][k];
                            dv_q_reg[gi+1][k]   <= dv_q_reg[gi][k];
                        end
                    end
                end
            end
        end
    endgenerate

    // Output stage: signed push, add to each center and saturate.
    carry_t           cf;
    logic [2:0][31:0] qf;
    result_t          res_next, res_reg;
    assign cf = dv_car_reg[DIV_STEPS];
    assign qf = dv_q_reg[DIV_STEPS];

    always_comb begin
        logic signed [33:0] corr [3];
        for (int k = 0; k < 3; k++) begin
            if (cf.hit && cf.zero) begin
                corr[k] = (k == 0) ? $signed(34'(cf.r[31:1])) : '0;
            end else if (cf.hit) begin
                corr[k] = cf.neg[k] ? -$signed(34'(qf[k])) : $signed(34'(qf[k]));
            end else begin
                corr[k] = '0;
            end
        end
        res_next.new_a_x    = sat32(34'($signed(cf.a[0])) + corr[0]);
        res_next.new_a_y    = sat32(34'($signed(cf.a[1])) + corr[1]);
        res_next.new_a_z    = sat32(34'($signed(cf.a[2])) + corr[2]);
        res_next.new_b_x    = sat32(34'($signed(cf.b[0])) - corr[0]);
        res_next.new_b_y    = sat32(34'($signed(cf.b[1])) - corr[1]);
        res_next.new_b_z    = sat32(34'($signed(cf.b[2])) - corr[2]);
        res_next.overlapped = cf.hit;
    end

    always_ff @(posedge clk) begin
        if (en[ST_OUT]) begin
            res_reg <= res_next;
        end
    end

    assign result_data = res_reg;

    // An overlapping pair always has a root strictly below the radius sum.
    a_root_below_r: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_PROD-1] && sq_car_reg[SQ_STEPS].hit
            |-> sq_root_reg[SQ_STEPS] < sq_car_reg[SQ_STEPS].r)
        else $error("square root not below radius sum");

    // Coincident centers give a zero root.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_PROD-1] && sq_car_reg[SQ_STEPS].zero |-> sq_root_reg[SQ_STEPS] == '0)
        else $error("nonzero root for coincident centers");

    // The push never exceeds half the radius sum, so it fits in 31 bits.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_OUT-1] && cf.hit && !cf.zero
            |-> !qf[0][31] && !qf[1][31] && !qf[2][31])
        else $error("push magnitude out of range");

endmodule

// File: tb/sphere_pair_collision_resolve_tb.sv
`timescale 1ns / 1ps

// Testbench for the sphere pair overlap correction block.
// Pair beats are driven with random gaps and result beats are taken with
// random stalls. Every accepted pair beat is run through a predictor that
// works in least steps with wide integers, and the expected result is
// queued. Each result beat must match the oldest queued result exactly.

class overlap_scoreboard;
    spcr_pkg::result_t pending[$];
    int mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Integer square root, floor, of a value below 2^100.
    static function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int bitpos = 51; bitpos >= 0; bitpos--) begin
            trial = root | (64'd1 << bitpos);
            if ({64'd0, trial} * {64'd0, trial} <= s) begin
                root = trial;
            end
        end
        return root;
    endfunction

    static function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    static function automatic spcr_pkg::result_t resolve(spcr_pkg::pair_t p);
        spcr_pkg::result_t res;
        logic signed [63:0] av[3];
        logic signed [63:0] bv[3];
        logic signed [63:0] dv[3];
        logic signed [63:0] push[3];
        logic [63:0] mag[3];
        logic [63:0] rsum;
        logic [127:0] sq;
        logic [63:0] root_len;
        logic [127:0] quot;
        logic hit;
        av[0] = p.a_pos_x; av[1] = p.a_pos_y; av[2] = p.a_pos_z;
        bv[0] = p.b_pos_x; bv[1] = p.b_pos_y; bv[2] = p.b_pos_z;
        rsum = {33'd0, p.a_radius} + {33'd0, p.b_radius};
        sq = 0;
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            dv[k] = av[k] - bv[k];
            mag[k] = dv[k] < 0 ? -dv[k] : dv[k];
            push[k] = 0;
            if (mag[k] >= rsum) begin
                hit = 1'b0;
            end
            sq += {64'd0, mag[k]} * {64'd0, mag[k]};
        end
        if (hit) begin
            hit = sq < {64'd0, rsum} * {64'd0, rsum};
        end
        if (hit) begin
            if (sq == 0) begin
                // Coincident centers: the whole radius sum is overlap, so A moves
                // half of it along +x and B half of it along -x.
                push[0] = rsum >> 1;
            end else begin
                root_len = isqrt(sq);
                for (int k = 0; k < 3; k++) begin
                    quot = ({64'd0, mag[k]} * {64'd0, rsum - root_len})
                           / {63'd0, root_len, 1'b0};
                    push[k] = dv[k] < 0 ? -$signed(quot[63:0]) : $signed(quot[63:0]);
                end
            end
        end
        res.new_a_x = clamp32(av[0] + push[0]);
        res.new_a_y = clamp32(av[1] + push[1]);
        res.new_a_z = clamp32(av[2] + push[2]);
        res.new_b_x = clamp32(bv[0] - push[0]);
        res.new_b_y = clamp32(bv[1] - push[1]);
        res.new_b_z = clamp32(bv[2] - push[2]);
        res.overlapped = hit;
        return res;
    endfunction

    function void note_pair(spcr_pkg::pair_t p);
        pending.push_back(resolve(p));
    endfunction

    function void check_result(spcr_pkg::result_t got);
        spcr_pkg::result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result beat %h", got);
            end
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) ov=%0b",
                         want.new_a_x, want.new_a_y, want.new_a_z,
                         want.new_b_x, want.new_b_y, want.new_b_z, want.overlapped);
                $display("          actual   a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) ov=%0b",
                         got.new_a_x, got.new_a_y, got.new_a_z,
                         got.new_b_x, got.new_b_y, got.new_b_z, got.overlapped);
            end
        end
    endfunction
endclass

module sphere_pair_collision_resolve_tb
    import spcr_pkg::*;
();

    logic    clk;
    logic    rst_n;
    logic    pair_valid;
    logic    pair_ready;
    pair_t   pair_data;
    logic    result_valid;
    logic    result_ready;
    result_t result_data;

    overlap_scoreboard board;
    bit stimulus_done;

    sphere_pair_collision_resolve dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair_data    (pair_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random full-range word; sometimes an extreme value.
    function automatic logic [31:0] any_word();
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Random pair. Most pairs sit close together with radii of matching scale so
    // that the overlap path, the square root and the divider are exercised deeply.
    // Some sit near the range edges so that the push saturates.
    function automatic pair_t random_pair();
        pair_t p;
        int scale;
        logic signed [31:0] base[3];
        scale = $urandom_range(0, 30);
        for (int k = 0; k < 3; k++) begin
            base[k] = $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'sh7FFF_FF00 : 32'sh8000_0100) : $urandom;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                p.a_pos_x = any_word(); p.a_pos_y = any_word(); p.a_pos_z = any_word();
                p.b_pos_x = any_word(); p.b_pos_y = any_word(); p.b_pos_z = any_word();
                p.a_radius = 31'(any_word()); p.b_radius = 31'(any_word());
            end
            default: begin
                p.a_pos_x = base[0] + ($signed($urandom) >>> (31 - scale));
                p.a_pos_y = base[1] + ($signed($urandom) >>> (31 - scale));
                p.a_pos_z = base[2] + ($signed($urandom) >>> (31 - scale));
                p.b_pos_x = base[0] + ($signed($urandom) >>> (31 - scale));
                p.b_pos_y = base[1] + ($signed($urandom) >>> (31 - scale));
                p.b_pos_z = base[2] + ($signed($urandom) >>> (31 - scale));
                p.a_radius = 31'($urandom >> (32 - scale));
                p.b_radius = 31'($urandom >> (32 - scale));
                if ($urandom_range(0, 15) == 0) begin
                    // Centers that coincide exactly.
                    p.b_pos_x = p.a_pos_x; p.b_pos_y = p.a_pos_y; p.b_pos_z = p.a_pos_z;
                end
            end
        endcase
        return p;
    endfunction

    // Drives one pair beat after a random gap and waits for its acceptance.
    // Valid stays high after acceptance so that a beat with no gap follows
    // directly; the caller drops it when the sender goes idle.
    task automatic send_pair(pair_t p);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair_data  <= p;
        @(posedge clk);
        while (!pair_ready) @(posedge clk);
        board.note_pair(p);
    endtask

    function automatic pair_t make_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                        logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                        logic [30:0] ra, logic [30:0] rb);
        pair_t p;
        p.a_pos_x = ax; p.a_pos_y = ay; p.a_pos_z = az;
        p.b_pos_x = bx; p.b_pos_y = by; p.b_pos_z = bz;
        p.a_radius = ra; p.b_radius = rb;
        return p;
    endfunction

    // Result side: stall a random number of cycles before each beat, with
    // stretches where the output never stalls.
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall == 0) begin
                result_ready <= 1'b1;
            end else begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                result_ready <= 1'b1;
            end
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            board.check_result(result_data);
        end
    end

    initial
    begin
        pair_t p;
        board = new();
        stimulus_done = 0;
        pair_valid = 1'b0;
        pair_data  = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: zero radii, coincident centers, single-axis far pairs,
        // tangent spheres, extreme coordinates and radii, and saturating pushes.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 31'd0, 31'd0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
        send_pair(make_pair(5, 5, 5, 5, 5, 5, 31'd1, 31'd0));
        send_pair(make_pair(5, 5, 5, 5, 5, 5, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h0003_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0002_0000));
        send_pair(make_pair(32'h0002_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 31'h0002_0000));
        send_pair(make_pair(0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                            31'h0001_0000, 31'h0001_0000));
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 31'h0001_0000, 31'd0));
        send_pair(make_pair(32'hFFFF_0000, 32'h0000_8000, 0, 0, 0, 0, 31'h0001_0000, 31'd1));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF0,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0010, 32'h8000_0010, 32'h8000_0010,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(0, 0, 32'h0010_0000, 0, 0, 0, 31'h0000_8000, 31'h0000_8000));
        send_pair(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                            31'h0000_0010, 31'h0000_0010));
        pair_valid <= 1'b0;

        // Hold the sender until the pipeline has drained completely.
        while (board.pending.size() != 0) @(posedge clk);

        for (int n = 0; n < 1500; n++) begin
            p = random_pair();
            send_pair(p);
        end
        pair_valid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Worst case is roughly 1500 beats times their gaps and stalls plus the
    // pipeline depth; allow plenty of margin.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
src/spcr_pkg.sv
src/sphere_pair_collision_resolve.sv
tb/sphere_pair_collision_resolve_tb.sv
